/* rtl/vn2d_pkg.sv */
// ----------------------------------------------------------------------------
// vn2d_pkg: shared types and constants for the 2-D value noise pipeline
// Holds the coordinate format, the hash constants and the stage enable type.
// ----------------------------------------------------------------------------
package vn2d_pkg;

  // Fraction bits of the input coordinates (valid range 8 to 24).
  localparam int FRAC_BITS = 16;
  localparam logic [31:0] FRAC_MASK = 32'((64'd1 << FRAC_BITS) - 64'd1);

  // Integer noise hash constants.
  localparam logic [31:0] HASH_ROW  = 32'd57;
  localparam logic [31:0] HASH_MUL  = 32'd15731;
  localparam logic [31:0] HASH_ADD1 = 32'd789221;
  localparam logic [31:0] HASH_ADD2 = 32'd1376312589;

  // 1.0 in Q16 and the smoothstep constant 3.0 in Q16.
  localparam logic [17:0] ONE_Q16   = 18'd65536;
  localparam logic [17:0] THREE_Q16 = 18'd196608;

  // Load enables of the first four pipeline stages, shared with the corner units.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } vn2d_en_t;

  // Converts the fraction bits of a coordinate to a Q16 fraction.
  function automatic logic [15:0] to_q16(input logic [31:0] c);
    logic [47:0] w;
    w = {16'd0, c & FRAC_MASK} << 16;
    w = w >> FRAC_BITS;
    return w[15:0];
  endfunction

endpackage

/* rtl/vn2d_corner.sv */
// ----------------------------------------------------------------------------
// vn2d_corner: pipelined lattice corner hash
// Hashes one integer lattice corner over four stages and maps it to Q16.
// ----------------------------------------------------------------------------
module vn2d_corner (
  input  logic                clk,
  input  vn2d_pkg::vn2d_en_t  en,
  input  logic [31:0]         cx,
  input  logic [31:0]         cy,
  output logic signed [17:0]  corner_val
);
  import vn2d_pkg::*;

  logic [31:0] n1;
  logic [31:0] n2;
  logic [31:0] n3;
  logic [31:0] nn;
  logic [31:0] p;
  logic [31:0] q;
  logic [31:0] seed;

  assign seed = cx + 32'(cy * HASH_ROW);
  assign q    = 32'(n3 * p) + HASH_ADD2;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      n1 <= (seed << 13) ^ seed;
    end
    if (en.s2) begin
      n2 <= n1;
      nn <= 32'(n1 * n1);
    end
    if (en.s3) begin
      n3 <= n2;
      p  <= 32'(nn * HASH_MUL) + HASH_ADD1;
    end
    if (en.s4) begin
      // The top bit is masked off, so q >> 14 uses bits 30 to 14.
      corner_val <= $signed(ONE_Q16 - {1'b0, q[30:14]});
    end
  end

endmodule

/* rtl/value_noise_2d.sv */
// ----------------------------------------------------------------------------
// value_noise_2d: two-dimensional value noise with smoothstep easing
// Hashes the four lattice corners around a point and blends them bilinearly.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   x_coord[31:0], y_coord[31:0]
// output    out        out_valid / out_ready noise_value[17:0] (signed Q16)
//
// The block is a six stage pipeline and takes one beat per cycle while the
// output is not held; a point moves through the stage registers in order and
// its result waits in the output register until the beat is taken.
// The latency is set by the corner hash, which needs three multiplies in a row.
// Every stage has its own valid bit and loads when it is empty or when the stage
// after it moves, so bubbles close up and a held output stalls only as far back
// as the pipeline is full. Reset clears the valid bits only, not the data.
//
// Stage plan:
//   1: corner seeds (ix + iy*57, shift and xor), Q16 fractions.
//   2: n*n for each corner, f*f for each fraction.
//   3: n*n*15731 + 789221, smoothstep s = f2*(3 - 2f).
//   4: final hash product and corner value, bilinear weights.
//   5: corner value times weight, truncated toward zero.
//   6: sum of the four terms into the output register.
//
module value_noise_2d (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        x_coord,
  input  logic [31:0]        y_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] noise_value
);
  import vn2d_pkg::*;

  // Stage valid bits and load enables.
  logic [6:1] v;
  logic [6:1] en;
  vn2d_en_t   hash_en;

  // Lattice corners around the point; the +1 corner cannot wrap.
  logic [31:0] ix0;
  logic [31:0] ix1;
  logic [31:0] iy0;
  logic [31:0] iy1;

  // Fraction path.
  logic [15:0] fx1, fy1;
  logic [15:0] fx2, fy2;
  logic [15:0] fx2sq, fy2sq;
  logic [31:0] fx_sq, fy_sq;
  logic [17:0] kx, ky;
  logic [33:0] sx_prod, sy_prod;
  logic [15:0] sx3, sy3;
  logic [16:0] rx, ry;
  logic [33:0] p00, p10, p01, p11;
  logic [16:0] w00, w10, w01, w11;

  // Corner values from the hash units, aligned with stage 4.
  logic signed [17:0] c00, c10, c01, c11;

  // Weighted terms and the blend.
  logic signed [17:0] t00, t10, t01, t11;
  logic signed [19:0] sum;

  // Enables: the last stage moves when it is empty or being taken, and each
  // earlier stage moves when it is empty or the next one moves.
  always_comb begin
    en[6] = !v[6] || out_ready;
    en[5] = !v[5] || en[6];
    en[4] = !v[4] || en[5];
    en[3] = !v[3] || en[4];
    en[2] = !v[2] || en[3];
    en[1] = !v[1] || en[2];
  end

  assign in_ready  = en[1];
  assign out_valid = v[6];

  assign hash_en.s1 = en[1];
  assign hash_en.s2 = en[2];
  assign hash_en.s3 = en[3];
  assign hash_en.s4 = en[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
      if (en[5]) v[5] <= v[4];
      if (en[6]) v[6] <= v[5];
    end
  end

  assign ix0 = {{FRAC_BITS{1'b0}}, x_coord[31:FRAC_BITS]};
  assign iy0 = {{FRAC_BITS{1'b0}}, y_coord[31:FRAC_BITS]};
  assign ix1 = ix0 + 32'd1;
  assign iy1 = iy0 + 32'd1;

  vn2d_corner u_c00 (.clk(clk), .en(hash_en), .cx(ix0), .cy(iy0), .corner_val(c00));
  vn2d_corner u_c10 (.clk(clk), .en(hash_en), .cx(ix1), .cy(iy0), .corner_val(c10));
  vn2d_corner u_c01 (.clk(clk), .en(hash_en), .cx(ix0), .cy(iy1), .corner_val(c01));
  vn2d_corner u_c11 (.clk(clk), .en(hash_en), .cx(ix1), .cy(iy1), .corner_val(c11));

  // Smoothstep: f2 = (f*f) >> 16, then s = (f2 * (3.0 - 2f)) >> 16. The eased
  // value never reaches 1.0, so it fits 16 bits and 1 - s fits 17 bits.
  assign fx_sq   = {16'd0, fx1} * {16'd0, fx1};
  assign fy_sq   = {16'd0, fy1} * {16'd0, fy1};
  assign kx      = THREE_Q16 - {1'b0, fx2, 1'b0};
  assign ky      = THREE_Q16 - {1'b0, fy2, 1'b0};
  assign sx_prod = {18'd0, fx2sq} * {16'd0, kx};
  assign sy_prod = {18'd0, fy2sq} * {16'd0, ky};
  assign rx      = ONE_Q16[16:0] - {1'b0, sx3};
  assign ry      = ONE_Q16[16:0] - {1'b0, sy3};
  assign p00     = {17'd0, rx} * {17'd0, ry};
  assign p10     = {17'd0, {1'b0, sx3}} * {17'd0, ry};
  assign p01     = {17'd0, rx} * {17'd0, {1'b0, sy3}};
  assign p11     = {17'd0, {1'b0, sx3}} * {17'd0, {1'b0, sy3}};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fx1 <= to_q16(x_coord);
      fy1 <= to_q16(y_coord);
    end
    if (en[2]) begin
      fx2   <= fx1;
      fy2   <= fy1;
      fx2sq <= fx_sq[31:16];
      fy2sq <= fy_sq[31:16];
    end
    if (en[3]) begin
      sx3 <= sx_prod[31:16];
      sy3 <= sy_prod[31:16];
    end
    if (en[4]) begin
      // Each weight is at most 1.0, so bits 32 to 16 hold it.
      w00 <= p00[32:16];
      w10 <= p10[32:16];
      w01 <= p01[32:16];
      w11 <= p11[32:16];
    end
  end

  // Product of a corner value and its weight, divided by 65536 with the
  // fraction cut toward zero: negative products are biased before the shift.
  function automatic logic signed [17:0] weigh(input logic signed [17:0] cv,
                                               input logic [16:0] w);
    logic signed [35:0] prod;
    logic signed [35:0] biased;
    prod   = cv * $signed({1'b0, w});
    biased = prod + (prod[35] ? 36'sd65535 : 36'sd0);
    return biased[33:16];
  endfunction

  assign sum = 20'(t00) + 20'(t10) + 20'(t01) + 20'(t11);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      t00 <= weigh(c00, w00);
      t10 <= weigh(c10, w10);
      t01 <= weigh(c01, w01);
      t11 <= weigh(c11, w11);
    end
    if (en[6]) begin
      noise_value <= sum[17:0];
    end
  end

`ifndef SYNTHESIS
  // The four bilinear weights never add up to more than 1.0.
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    v[5] |-> (19'(w00) + 19'(w10) + 19'(w01) + 19'(w11)) <= 19'(ONE_Q16))
    else $error("bilinear weights exceed 1.0");

  // A valid result on the output stays within -1.0 to 1.0.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (noise_value <= 18'sd65536) && (noise_value >= -18'sd65536))
    else $error("noise value out of range");

  // While the output side takes beats the whole pipeline moves, so the input
  // side must be open.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled although the output is draining");
`endif

endmodule

/* verif/value_noise_2d_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_tb: self-checking bench for the 2-D value noise pipeline
// Sends sample points through the valid/ready input and predicts every noise
// value with a behavioral model. Each output beat is checked in order against
// that prediction under random idles on both sides and one output hold-off.
// ----------------------------------------------------------------------------
module value_noise_2d_tb;

  // The fraction width of the coordinates is fixed by the design package.
  localparam int          FB          = vn2d_pkg::FRAC_BITS;
  localparam logic [31:0] FRAC_FIELD  = 32'((64'd1 << FB) - 64'd1);
  localparam logic [31:0] Q16_ONE     = 32'd65536;

  // The pipeline is six stages deep; the settle wait adds a margin beyond that
  // depth so that any beat still in flight shows up at the output.
  localparam int PIPE_DEPTH    = 6;
  localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;
  localparam int HOLD_CYCLES   = 150;
  localparam int CYCLE_LIMIT   = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        x_coord = '0;
  logic [31:0]        y_coord = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [17:0] noise_value;

  // One expected output beat, kept with the point that produced it so that a
  // mismatch report can name the coordinates.
  typedef struct {
    logic [31:0]        x;
    logic [31:0]        y;
    logic signed [17:0] noise;
  } noise_expect_t;

  noise_expect_t pending_noise[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;
  int hold_left     = 0;
  int points_sent   = 0;
  int values_seen   = 0;
  int stall_cycles  = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  value_noise_2d dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .noise_value (noise_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Noise predictor
  // --------------------------------------------------------------------------

  // The fraction bits of a coordinate as a Q16 fraction. Extra low bits are
  // dropped for wide fractions and zeros appended for narrow ones.
  function automatic logic [15:0] frac_q16(logic [31:0] c);
    logic [31:0] f;
    f = c & FRAC_FIELD;
    if (FB >= 16) begin
      return 16'(f >> (FB - 16));
    end else begin
      return 16'(f << (16 - FB));
    end
  endfunction

  // Hash of one lattice corner in 32-bit wraparound, mapped to 1 - t/2^30 in
  // Q16 with the fraction truncated. The result lies in [-65535, 65536].
  function automatic longint lattice_value(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] n;
    logic [31:0] t;
    n = cx + cy * 32'd57;
    n = (n << 13) ^ n;
    t = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
    return 64'sd65536 - longint'({32'd0, t >> 14});
  endfunction

  // Smoothstep s = f*f*(3 - 2f) in Q16; both products truncate.
  function automatic logic [31:0] smooth_frac(logic [15:0] f);
    logic [63:0] f2;
    f2 = ({48'd0, f} * {48'd0, f}) >> 16;
    return 32'((f2 * (64'd196608 - 64'd2 * {48'd0, f})) >> 16);
  endfunction

  // Corner value times weight in Q16, truncated toward zero.
  function automatic longint weighted_term(longint v, logic [31:0] w);
    longint p;
    p = v * longint'({32'd0, w});
    if (p >= 0) begin
      return p >>> 16;
    end else begin
      return -((-p) >>> 16);
    end
  endfunction

  // Full noise value for one sample point, reduced to the 18-bit output.
  function automatic logic signed [17:0] noise_at(logic [31:0] x, logic [31:0] y);
    logic [31:0] ix;
    logic [31:0] iy;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [63:0] w00;
    logic [63:0] w10;
    logic [63:0] w01;
    logic [63:0] w11;
    longint      acc;
    ix  = x >> FB;
    iy  = y >> FB;
    sx  = smooth_frac(frac_q16(x));
    sy  = smooth_frac(frac_q16(y));
    rx  = Q16_ONE - sx;
    ry  = Q16_ONE - sy;
    w00 = ({32'd0, rx} * {32'd0, ry}) >> 16;
    w10 = ({32'd0, sx} * {32'd0, ry}) >> 16;
    w01 = ({32'd0, rx} * {32'd0, sy}) >> 16;
    w11 = ({32'd0, sx} * {32'd0, sy}) >> 16;
    acc = weighted_term(lattice_value(ix, iy), w00[31:0])
        + weighted_term(lattice_value(ix + 32'd1, iy), w10[31:0])
        + weighted_term(lattice_value(ix, iy + 32'd1), w01[31:0])
        + weighted_term(lattice_value(ix + 32'd1, iy + 32'd1), w11[31:0]);
    return acc[17:0];
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one point and returns at the edge where it is accepted. Valid is
  // only lowered when an idle cycle is actually inserted, so back-to-back
  // beats keep it high without a drop in the same time step. The predicted
  // value is queued at the accepting edge.
  task automatic offer_point(logic [31:0] x, logic [31:0] y);
    noise_expect_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord  <= x;
    y_coord  <= y;
    @(posedge clk);
    while (!in_ready) begin
      stall_cycles++;
      @(posedge clk);
    end
    e.x     = x;
    e.y     = y;
    e.noise = noise_at(x, y);
    pending_noise.push_back(e);
    points_sent++;
  endtask

  // Lowers valid and waits until every queued value has come out, then lets
  // the pipeline settle before the next phase.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_noise.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Picks a random point. Half are fully random; the rest aim at lattice
  // points, all-ones or one-half fractions, small integer parts and the top
  // integer edge, where ix+1 or iy+1 is formed from the largest integer part.
  function automatic logic [31:0] pick_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(9))
      0:       c = c & ~FRAC_FIELD;
      1:       c = c | FRAC_FIELD;
      2:       c = c | ~FRAC_FIELD;
      3:       c = (c & FRAC_FIELD) | (32'($urandom_range(3)) << FB);
      4:       c = {c[31:FB], 1'b1, {(FB - 1){1'b0}}};
      default: c = c;
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // The receiver drops ready at random, or for a long counted stretch when a
  // hold-off is requested. Only this process writes out_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted output beat is compared with the oldest prediction.
  always @(posedge clk) begin
    noise_expect_t e;
    if (!rst && out_valid && out_ready) begin
      values_seen++;
      if (pending_noise.size() == 0) begin
        $error("noise_value: expected none, got %0d", noise_value);
        mismatches++;
      end else begin
        e = pending_noise.pop_front();
        if (noise_value !== e.noise) begin
          $error("noise_value: expected %0d, got %0d (x=%h y=%h)",
                 e.noise, noise_value, e.x, e.y);
          mismatches++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases first: the coordinate extremes, lattice points where the
  // result is a single corner value, fractions at zero, one half and just
  // below one, and the top integer edge on each axis.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    offer_point(32'h0000_0000, 32'h0000_0000);
    offer_point(32'hffff_ffff, 32'hffff_ffff);
    offer_point(32'h0000_0000, 32'hffff_ffff);
    offer_point(32'hffff_ffff, 32'h0000_0000);
    offer_point(~FRAC_FIELD, ~FRAC_FIELD);
    offer_point(FRAC_FIELD, FRAC_FIELD);
    offer_point(FRAC_FIELD, 32'h0000_0000);
    offer_point(32'h0000_0000, FRAC_FIELD);
    offer_point(32'd1 << (FB - 1), 32'd1 << (FB - 1));
    offer_point(32'd1 << FB, 32'd0);
    offer_point(32'd0, 32'd1 << FB);
    offer_point(32'd1 << FB, 32'd1 << FB);
    offer_point(32'd1, 32'd1);
    offer_point(~FRAC_FIELD | 32'd1, FRAC_FIELD);
    offer_point(32'h5555_5555, 32'haaaa_aaaa);
    offer_point(32'haaaa_aaaa, 32'h5555_5555);
    offer_point(32'h1234_5678, 32'h9abc_def0);
    offer_point(32'h0001_8000, 32'h0003_4000);
    drain_pipeline();
  endtask

  // A block of random points under one idle mix.
  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) offer_point(pick_coord(), pick_coord());
    drain_pipeline();
  endtask

  // The receiver holds off for a long stretch while points keep coming, so
  // the pipeline fills and input ready falls. The sender then waits on ready.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (40) offer_point(pick_coord(), pick_coord());
    drain_pipeline();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(600, 29, 68);
    test_random(600, 68, 29);
    test_output_hold();
    test_random(400, 0, 0);

    $display("Checked %0d noise values from %0d points (%0d input stall cycles),",
             values_seen, points_sent, stall_cycles);
    $display("covering edge points, three idle mixes and a long output hold-off.");
    if (mismatches == 0 && pending_noise.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/vn2d_pkg.sv
rtl/vn2d_corner.sv
rtl/value_noise_2d.sv
verif/value_noise_2d_tb.sv
